### sv/bphc_pkg.sv
// Shared types, constants and helper functions for the bone pose compose block.
package bphc_pkg;

  localparam int MAX_BONES = 256;
  localparam int ADDR_W    = $clog2(MAX_BONES);
  localparam int T_W       = 32;
  localparam int Q_W       = 16;
  localparam int POSE_W    = 3 * T_W + 4 * Q_W;
  localparam int S_W       = 20;
  localparam int SUM_W     = 42;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int QUO_W     = 15;
  localparam int STEP_W    = 5;

  localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;

  typedef enum logic [2:0] {
    C_IDLE, C_MUL1, C_SUM1, C_MUL2, C_SUM2, C_NORM, C_OUT
  } core_state_t;

  typedef enum logic [1:0] {
    N_IDLE, N_SQRT, N_DIV
  } norm_state_t;

  typedef struct packed {
    logic                         start;
    logic [SUM_W-1:0]             sq_sum;
    logic [3:0][S_W-1:0]          s;
  } norm_req_t;

  typedef struct packed {
    logic                         done;
    logic [3:0][Q_W-1:0]          q;
  } norm_rsp_t;

  // round half up at bit 14, then drop 14 fraction bits
  function automatic logic signed [39:0] rnd14(input logic signed [53:0] x);
    logic signed [53:0] y;
    y = (x + 54'sd8192) >>> 14;
    return y[39:0];
  endfunction

  function automatic logic signed [T_W-1:0] sat32(input logic signed [43:0] x);
    if (x > 44'sd2147483647) return 32'sh7fffffff;
    if (x < -44'sd2147483648) return 32'sh80000000;
    return x[T_W-1:0];
  endfunction

endpackage

### sv/bphc_if.sv
// Valid/ready channel interfaces for bone items and world pose items.
interface bphc_in_if;
  import bphc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ADDR_W-1:0]       bone_index;
  logic [ADDR_W-1:0]       parent_index;
  logic signed [T_W-1:0]   local_tx;
  logic signed [T_W-1:0]   local_ty;
  logic signed [T_W-1:0]   local_tz;
  logic signed [Q_W-1:0]   local_qw;
  logic signed [Q_W-1:0]   local_qx;
  logic signed [Q_W-1:0]   local_qy;
  logic signed [Q_W-1:0]   local_qz;
  modport source (output valid, bone_index, parent_index, local_tx, local_ty, local_tz,
                  local_qw, local_qx, local_qy, local_qz, input ready);
  modport sink   (input valid, bone_index, parent_index, local_tx, local_ty, local_tz,
                  local_qw, local_qx, local_qy, local_qz, output ready);
endinterface

interface bphc_out_if;
  import bphc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ADDR_W-1:0]       out_bone_index;
  logic signed [T_W-1:0]   world_tx;
  logic signed [T_W-1:0]   world_ty;
  logic signed [T_W-1:0]   world_tz;
  logic signed [Q_W-1:0]   world_qw;
  logic signed [Q_W-1:0]   world_qx;
  logic signed [Q_W-1:0]   world_qy;
  logic signed [Q_W-1:0]   world_qz;
  modport source (output valid, out_bone_index, world_tx, world_ty, world_tz,
                  world_qw, world_qx, world_qy, world_qz, input ready);
  modport sink   (input valid, out_bone_index, world_tx, world_ty, world_tz,
                  world_qw, world_qx, world_qy, world_qz, output ready);
endinterface

### sv/bphc_pose_ram.sv
// World pose store: one write port, one registered read port.
module bphc_pose_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [bphc_pkg::ADDR_W-1:0]   waddr,
  input  logic [bphc_pkg::POSE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [bphc_pkg::ADDR_W-1:0]   raddr,
  output logic [bphc_pkg::POSE_W-1:0]   rdata
);
  import bphc_pkg::*;

  logic [POSE_W-1:0] mem [MAX_BONES];
  logic [POSE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### sv/bphc_norm.sv
// Quaternion normalizer: bit-serial square root, then four shared-step restoring dividers.
module bphc_norm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bphc_pkg::norm_req_t   req,
  output bphc_pkg::norm_rsp_t   rsp
);
  import bphc_pkg::*;

  norm_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r;
  logic [SUM_W-1:0]   x_r;
  logic [ROOT_W+4:0]  rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [S_W-1:0]     mag_r [4];
  logic [3:0]         neg_r;
  logic [34:0]        dd_r [4];
  logic [34:0]        dv_r;
  logic [QUO_W-1:0]   quo_r [4];
  logic               done_r;
  logic               zero_r;

  logic [ROOT_W+4:0]  rem_sh;
  logic [ROOT_W+4:0]  trial;
  logic               fit;
  logic               last;

  assign rem_sh = {rem_r[ROOT_W+2:0], x_r[SUM_W-1 -: 2]};
  assign trial  = {3'b000, root_r, 2'b01};
  assign fit    = rem_sh >= trial;
  assign last   = cnt_r == '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE: if (req.start) state_nxt = N_SQRT;
      N_SQRT: if (last) state_nxt = N_DIV;
      N_DIV:  if (last || zero_r) state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == N_DIV) && (last || zero_r);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        x_r    <= req.sq_sum;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= STEP_W'(ROOT_W - 1);
        for (int i = 0; i < 4; i++) begin
          neg_r[i] <= req.s[i][S_W-1];
          mag_r[i] <= req.s[i][S_W-1] ? S_W'(-$signed(req.s[i])) : req.s[i];
        end
      end
      N_SQRT: begin
        x_r <= {x_r[SUM_W-3:0], 2'b00};
        if (fit) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= last ? STEP_W'(QUO_W - 1) : cnt_r - 1'b1;
        if (last) begin
          // seed the dividers with the finished root
          zero_r <= !fit && (root_r == '0);
          dv_r   <= {root_r[ROOT_W-2:0], fit, 14'b0};
          for (int i = 0; i < 4; i++) begin
            dd_r[i]  <= {1'b0, mag_r[i], 14'b0} + 35'({root_r});
            quo_r[i] <= '0;
          end
        end
      end
      N_DIV: begin
        cnt_r <= cnt_r - 1'b1;
        dv_r  <= dv_r >> 1;
        for (int i = 0; i < 4; i++) begin
          if (dd_r[i] >= dv_r) begin
            dd_r[i]  <= dd_r[i] - dv_r;
            quo_r[i] <= {quo_r[i][QUO_W-2:0], 1'b1};
          end else begin
            quo_r[i] <= {quo_r[i][QUO_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done = done_r;
    for (int i = 0; i < 4; i++) begin
      if (zero_r) begin
        rsp.q[i] = (i == 0) ? Q_ONE : '0;
      end else begin
        rsp.q[i] = neg_r[i] ? Q_W'(-$signed({1'b0, quo_r[i]})) : Q_W'(quo_r[i]);
      end
    end
  end
endmodule

### sv/bone_pose_hierarchy_compose_core.sv
// Bone pose compose core: one bone item in, its world pose item out.
// From acceptance to a valid result each item passes through the product and sum states MUL1,
// SUM1, MUL2 and SUM2, 21 square root steps and 15 divide steps in the normalizer (one divide step
// when the norm is zero), and a register for the quotient. The input opens in the cycle after the
// result is taken.
// The parent's pose is read from the pose store when the item is accepted and the new pose
// is written when the result is loaded, so a child may follow its parent immediately.
// Items are processed one at a time; the input is ready only when the core is idle.
module bone_pose_hierarchy_compose_core (
  input  logic        clk,
  input  logic        rst_n,
  bphc_in_if.sink     in_ch,
  bphc_out_if.source  out_ch
);
  import bphc_pkg::*;

  core_state_t state_r, state_nxt;
  logic acc;

  logic [ADDR_W-1:0]     bone_r;
  logic signed [T_W-1:0] lt_r [3];
  logic signed [Q_W-1:0] lq_r [4];
  logic signed [T_W-1:0] pt_r [3];
  logic signed [Q_W-1:0] pq_r [4];
  logic signed [31:0]    hp_r [16];
  logic signed [47:0]    cp_r [6];
  logic signed [S_W-1:0] s_r  [4];
  logic signed [36:0]    t_r  [3];
  logic [39:0]           sq_r [4];
  logic signed [52:0]    wtp_r [3];
  logic signed [52:0]    utp_r [6];
  logic signed [T_W-1:0] wt_r [3];

  logic [POSE_W-1:0]     rdata;
  logic [POSE_W-1:0]     wdata;
  logic signed [T_W-1:0] rt [3];
  logic signed [Q_W-1:0] rq [4];
  logic                  we;

  logic [ADDR_W-1:0]     ob_r;
  logic signed [T_W-1:0] ot_r [3];
  logic signed [Q_W-1:0] oq_r [4];

  norm_req_t nreq;
  norm_rsp_t nrsp;

  assign acc = in_ch.valid && in_ch.ready;
  assign we  = (state_r == C_NORM) && nrsp.done;

  assign rt[0] = rdata[159:128];
  assign rt[1] = rdata[127:96];
  assign rt[2] = rdata[95:64];
  assign rq[0] = rdata[63:48];
  assign rq[1] = rdata[47:32];
  assign rq[2] = rdata[31:16];
  assign rq[3] = rdata[15:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (in_ch.valid) state_nxt = C_MUL1;
      C_MUL1: state_nxt = C_SUM1;
      C_SUM1: state_nxt = C_MUL2;
      C_MUL2: state_nxt = C_SUM2;
      C_SUM2: state_nxt = C_NORM;
      C_NORM: if (nrsp.done) state_nxt = C_OUT;
      C_OUT:  if (out_ch.ready) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = state_r == C_IDLE;
    out_ch.valid = state_r == C_OUT;
    nreq.start   = state_r == C_SUM2;
    nreq.sq_sum  = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    for (int i = 0; i < 4; i++) nreq.s[i] = s_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bone_r  <= in_ch.bone_index;
      lt_r[0] <= in_ch.local_tx;
      lt_r[1] <= in_ch.local_ty;
      lt_r[2] <= in_ch.local_tz;
      lq_r[0] <= in_ch.local_qw;
      lq_r[1] <= in_ch.local_qx;
      lq_r[2] <= in_ch.local_qy;
      lq_r[3] <= in_ch.local_qz;
    end
    case (state_r)
      C_MUL1: begin
        for (int i = 0; i < 3; i++) pt_r[i] <= rt[i];
        for (int i = 0; i < 4; i++) pq_r[i] <= rq[i];
        for (int a = 0; a < 4; a++) begin
          for (int b = 0; b < 4; b++) hp_r[a*4+b] <= rq[a] * lq_r[b];
        end
        cp_r[0] <= 48'(rq[2]) * 48'(lt_r[2]);
        cp_r[1] <= 48'(rq[3]) * 48'(lt_r[1]);
        cp_r[2] <= 48'(rq[3]) * 48'(lt_r[0]);
        cp_r[3] <= 48'(rq[1]) * 48'(lt_r[2]);
        cp_r[4] <= 48'(rq[1]) * 48'(lt_r[1]);
        cp_r[5] <= 48'(rq[2]) * 48'(lt_r[0]);
      end
      C_SUM1: begin
        logic signed [33:0] r [4];
        logic signed [50:0] c2;
        r[0] = 34'(hp_r[0]) - 34'(hp_r[5]) - 34'(hp_r[10]) - 34'(hp_r[15]);
        r[1] = 34'(hp_r[1]) + 34'(hp_r[4]) + 34'(hp_r[11]) - 34'(hp_r[14]);
        r[2] = 34'(hp_r[2]) - 34'(hp_r[7]) + 34'(hp_r[8]) + 34'(hp_r[13]);
        r[3] = 34'(hp_r[3]) + 34'(hp_r[6]) - 34'(hp_r[9]) + 34'(hp_r[12]);
        for (int i = 0; i < 4; i++) s_r[i] <= S_W'(r[i] >>> 14);
        for (int i = 0; i < 3; i++) begin
          c2 = ((51'(cp_r[2*i]) - 51'(cp_r[2*i+1])) <<< 1) + 51'sd8192;
          t_r[i] <= 37'(c2 >>> 14);
        end
      end
      C_MUL2: begin
        for (int i = 0; i < 4; i++) sq_r[i] <= 40'(s_r[i] * s_r[i]);
        for (int i = 0; i < 3; i++) wtp_r[i] <= 53'(pq_r[0]) * 53'(t_r[i]);
        utp_r[0] <= 53'(pq_r[2]) * 53'(t_r[2]);
        utp_r[1] <= 53'(pq_r[3]) * 53'(t_r[1]);
        utp_r[2] <= 53'(pq_r[3]) * 53'(t_r[0]);
        utp_r[3] <= 53'(pq_r[1]) * 53'(t_r[2]);
        utp_r[4] <= 53'(pq_r[1]) * 53'(t_r[1]);
        utp_r[5] <= 53'(pq_r[2]) * 53'(t_r[0]);
      end
      C_SUM2: begin
        logic signed [43:0] w;
        for (int i = 0; i < 3; i++) begin
          w = 44'(pt_r[i]) + 44'(lt_r[i]) + 44'(rnd14(54'(wtp_r[i])))
            + 44'(rnd14(54'(utp_r[2*i]) - 54'(utp_r[2*i+1])));
          wt_r[i] <= sat32(w);
        end
      end
      default: ;
    endcase
    if (we) begin
      ob_r <= bone_r;
      for (int i = 0; i < 3; i++) ot_r[i] <= (bone_r == '0) ? lt_r[i] : wt_r[i];
      for (int i = 0; i < 4; i++) begin
        oq_r[i] <= (bone_r == '0) ? lq_r[i] : $signed(nrsp.q[i]);
      end
    end
  end

  // root passes its local pose through unnormalized
  assign wdata = (bone_r == '0)
    ? {lt_r[0], lt_r[1], lt_r[2], lq_r[0], lq_r[1], lq_r[2], lq_r[3]}
    : {wt_r[0], wt_r[1], wt_r[2], nrsp.q[0], nrsp.q[1], nrsp.q[2], nrsp.q[3]};

  bphc_pose_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (bone_r),
    .wdata (wdata),
    .re    (acc),
    .raddr (in_ch.parent_index),
    .rdata (rdata)
  );

  bphc_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  assign out_ch.out_bone_index = ob_r;
  assign out_ch.world_tx = ot_r[0];
  assign out_ch.world_ty = ot_r[1];
  assign out_ch.world_tz = ot_r[2];
  assign out_ch.world_qw = oq_r[0];
  assign out_ch.world_qx = oq_r[1];
  assign out_ch.world_qy = oq_r[2];
  assign out_ch.world_qz = oq_r[3];

  a_store_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> out_ch.valid) else $error("pose store write without result");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input open while result pending");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == C_MUL1) else $error("accepted item did not start");
  a_norm_started: assert property (@(posedge clk) disable iff (!rst_n)
    nreq.start |=> state_r == C_NORM) else $error("normalizer start out of step");
endmodule

### test/bone_pose_checker.sv
// Checker for the bone pose compose core: predicts world poses and compares output items.
`timescale 1ns / 1ps

module bone_pose_checker (
  input  logic       clk,
  input  logic       rst_n,
  bphc_in_if         in_ch,
  bphc_out_if        out_ch,
  output int         fail_count,
  output int         pending
);
  import bphc_pkg::*;

  typedef struct {
    logic [7:0]         bone;
    logic signed [31:0] tx, ty, tz;
    logic signed [15:0] qw, qx, qy, qz;
  } world_pose_t;

  world_pose_t        expected_poses[$];
  logic signed [31:0] pos_x [MAX_BONES];
  logic signed [31:0] pos_y [MAX_BONES];
  logic signed [31:0] pos_z [MAX_BONES];
  logic signed [15:0] rot [MAX_BONES][4];
  int                 mismatches;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round14(longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Compose one bone against its stored parent and update the pose store.
  function automatic world_pose_t compose_bone();
    world_pose_t     p;
    longint          lt[3], lq[4], pt[3], pq[4], r[4], s[4], c[3], t[3], ut[3], wt[3];
    longint          q;
    longint unsigned sq_sum, n, mag;
    int              par;
    lt[0] = in_ch.local_tx; lt[1] = in_ch.local_ty; lt[2] = in_ch.local_tz;
    lq[0] = in_ch.local_qw; lq[1] = in_ch.local_qx;
    lq[2] = in_ch.local_qy; lq[3] = in_ch.local_qz;
    p.bone = in_ch.bone_index;
    par = in_ch.parent_index;
    if (p.bone == 0) begin
      p.tx = in_ch.local_tx; p.ty = in_ch.local_ty; p.tz = in_ch.local_tz;
      p.qw = in_ch.local_qw; p.qx = in_ch.local_qx;
      p.qy = in_ch.local_qy; p.qz = in_ch.local_qz;
    end else begin
      pt[0] = pos_x[par]; pt[1] = pos_y[par]; pt[2] = pos_z[par];
      for (int i = 0; i < 4; i++) pq[i] = rot[par][i];
      r[0] = pq[0]*lq[0] - pq[1]*lq[1] - pq[2]*lq[2] - pq[3]*lq[3];
      r[1] = pq[0]*lq[1] + pq[1]*lq[0] + pq[2]*lq[3] - pq[3]*lq[2];
      r[2] = pq[0]*lq[2] - pq[1]*lq[3] + pq[2]*lq[0] + pq[3]*lq[1];
      r[3] = pq[0]*lq[3] + pq[1]*lq[2] - pq[2]*lq[1] + pq[3]*lq[0];
      sq_sum = 0;
      for (int i = 0; i < 4; i++) begin
        s[i] = r[i] >>> 14;
        sq_sum += s[i] * s[i];
      end
      n = int_sqrt(sq_sum);
      if (n == 0) begin
        r[0] = 16384; r[1] = 0; r[2] = 0; r[3] = 0;
      end else begin
        for (int i = 0; i < 4; i++) begin
          mag = s[i] < 0 ? -s[i] : s[i];
          q = (mag * 16384 + n / 2) / n;
          if (s[i] < 0) q = -q;
          r[i] = q > 32767 ? 32767 : (q < -32768 ? -32768 : q);
        end
      end
      p.qw = r[0]; p.qx = r[1]; p.qy = r[2]; p.qz = r[3];
      // rotate the local offset by the parent rotation
      c[0] = pq[2]*lt[2] - pq[3]*lt[1];
      c[1] = pq[3]*lt[0] - pq[1]*lt[2];
      c[2] = pq[1]*lt[1] - pq[2]*lt[0];
      for (int i = 0; i < 3; i++) t[i] = round14(2 * c[i]);
      ut[0] = pq[2]*t[2] - pq[3]*t[1];
      ut[1] = pq[3]*t[0] - pq[1]*t[2];
      ut[2] = pq[1]*t[1] - pq[2]*t[0];
      for (int i = 0; i < 3; i++)
        wt[i] = pt[i] + lt[i] + round14(pq[0] * t[i]) + round14(ut[i]);
      p.tx = clamp32(wt[0]); p.ty = clamp32(wt[1]); p.tz = clamp32(wt[2]);
    end
    pos_x[p.bone] = p.tx; pos_y[p.bone] = p.ty; pos_z[p.bone] = p.tz;
    rot[p.bone][0] = p.qw; rot[p.bone][1] = p.qx;
    rot[p.bone][2] = p.qy; rot[p.bone][3] = p.qz;
    return p;
  endfunction

  always @(posedge clk) begin
    world_pose_t e;
    if (!rst_n) begin
      expected_poses.delete();
      fail_count <= 0;
      mismatches = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: bone %0d", out_ch.out_bone_index);
        end else begin
          e = expected_poses.pop_front();
          if (out_ch.out_bone_index !== e.bone || out_ch.world_tx !== e.tx ||
              out_ch.world_ty !== e.ty || out_ch.world_tz !== e.tz ||
              out_ch.world_qw !== e.qw || out_ch.world_qx !== e.qx ||
              out_ch.world_qy !== e.qy || out_ch.world_qz !== e.qz) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: bone %0d t %0d %0d %0d q %0d %0d %0d %0d",
                       e.bone, e.tx, e.ty, e.tz, e.qw, e.qx, e.qy, e.qz);
              $display("         got: bone %0d t %0d %0d %0d q %0d %0d %0d %0d",
                       out_ch.out_bone_index, out_ch.world_tx, out_ch.world_ty,
                       out_ch.world_tz, out_ch.world_qw, out_ch.world_qx,
                       out_ch.world_qy, out_ch.world_qz);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expected_poses.push_back(compose_bone());
      fail_count <= mismatches;
    end
  end

  assign pending = expected_poses.size();

endmodule

### test/tb_bone_pose_hierarchy_compose_core.sv
// Testbench top: clock, reset, bone item stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_bone_pose_hierarchy_compose_core;
  import bphc_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   hold_cycles;
  int   sent;
  int   roots;
  int   zero_rot;
  bit   written [256];
  int   last_bone;

  bphc_in_if  in_ch();
  bphc_out_if out_ch();

  bone_pose_hierarchy_compose_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  bone_pose_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                         .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_bone(input logic [7:0] bone, input logic [7:0] par,
                           input logic [31:0] tx, ty, tz,
                           input logic [15:0] qw, qx, qy, qz);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.bone_index <= bone;  in_ch.parent_index <= par;
    in_ch.local_tx <= tx; in_ch.local_ty <= ty; in_ch.local_tz <= tz;
    in_ch.local_qw <= qw; in_ch.local_qx <= qx; in_ch.local_qy <= qy; in_ch.local_qz <= qz;
    in_ch.valid <= 1;
    do @(posedge clk); while (!in_ch.ready);
    written[bone] = 1;
    last_bone = bone;
    sent++;
    if (bone == 0) roots++;
    if (qw == 0 && qx == 0 && qy == 0 && qz == 0) zero_rot++;
  endtask

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      default: return $urandom_range(32'h3ffff) - 32'h20000;
    endcase
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      default: return $urandom_range(16'h4000) - 16'h2000;
    endcase
  endfunction

  task automatic send_random();
    logic [7:0]  bone, par;
    logic [15:0] qw, qx, qy, qz;
    int          k;
    k = $urandom_range(15);
    bone = (k == 0) ? 8'd0 : $urandom;
    // prefer the bone just sent as parent; otherwise any stored bone
    if ($urandom_range(1) == 0) begin
      par = last_bone;
    end else begin
      do par = $urandom; while (!written[par]);
    end
    if (k == 1) begin
      qw = 0; qx = 0; qy = 0; qz = 0;
    end else if (k == 2) begin
      qw = 16'h4000; qx = 0; qy = 0; qz = 0;
    end else begin
      qw = rand_comp(); qx = rand_comp(); qy = rand_comp(); qz = rand_comp();
    end
    send_bone(bone, par, rand_offset(), rand_offset(), rand_offset(), qw, qx, qy, qz);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.bone_index = 0; in_ch.parent_index = 0;
    in_ch.local_tx = 0; in_ch.local_ty = 0; in_ch.local_tz = 0;
    in_ch.local_qw = 0; in_ch.local_qx = 0; in_ch.local_qy = 0; in_ch.local_qz = 0;
    idle_pct = 0; stall_pct = 0; hold_cycles = 0;
    sent = 0; roots = 0; zero_rot = 0; last_bone = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, saturation, zero rotation, self parent, top index
    send_bone(0, 8'hff, 32'h7fffffff, 32'h80000000, 32'hffffffff,
              16'h8000, 16'h7fff, 16'hffff, 16'h0000);
    send_bone(1, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_bone(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h4000, 0, 0, 0);
    send_bone(2, 0, 32'h7fffffff, 32'h00010000, 32'h80000000, 16'h4000, 0, 0, 0);
    send_bone(3, 2, 32'h80000000, 32'h80000000, 32'h80000000, 16'h2d41, 16'h2d41, 0, 0);
    send_bone(4, 3, 0, 0, 0, 0, 0, 0, 0);
    send_bone(5, 4, 32'h00010000, 32'hffff0000, 32'h00020000, 16'h1000, 0, 0, 0);
    send_bone(5, 5, 32'h00010000, 0, 0, 16'h2d41, 0, 16'h2d41, 0);
    send_bone(8'hff, 5, 32'h12345678, 32'hedcba987, 32'h0, 16'h0, 16'h4000, 0, 0);
    send_bone(8'haa, 8'hff, 32'h55555555, 32'haaaaaaaa, 32'h1, 0, 0, 16'h4000, 0);
    send_bone(8'h55, 8'haa, 32'hffffffff, 32'h1, 32'h7fffffff, 0, 0, 0, 16'h4000);
    send_bone(6, 8'h55, 32'h00008000, 32'h00004000, 0,
              16'hc000, 16'h4000, 16'hc000, 16'h4000);
    send_bone(7, 6, 0, 0, 0, 16'h0001, 0, 0, 0);
    send_bone(0, 7, 0, 0, 0, 0, 0, 0, 0);
    send_bone(9, 0, 32'h00010000, 32'h00010000, 32'h00010000, 16'h4000, 0, 0, 0);
    send_bone(0, 0, 0, 0, 0, 16'h4000, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 32) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 32) : 0;
      for (int i = 0; i < 170; i++) begin
        if (ph == 0 && i == 60) hold_cycles = 400;
        if (ph == 2 && i == 80) drain();
        send_random();
      end
      drain();
    end

    $display("sent %0d bone items (%0d roots, %0d zero rotations) over four idle/stall mixes",
             sent, roots, zero_rot);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/bphc_pkg.sv
sv/bphc_if.sv
sv/bphc_pose_ram.sv
sv/bphc_norm.sv
sv/bone_pose_hierarchy_compose_core.sv
test/bone_pose_checker.sv
test/tb_bone_pose_hierarchy_compose_core.sv
